// ===== hw/rtl/rps_pkg.sv =====
// Shared types for the rank placement sort unit.
// Word formats, controller states and controller/datapath command and status.
package rps_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_I,
    ST_LATCH_I,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT_START,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;       // write incoming word to store
    logic fill_clr;
    logic i_zero;
    logic i_step;
    logic j_zero;     // read address 0
    logic j_step;     // read address j+1; neither: read address i
    logic latch_cur;
    logic cnt_clr;
    logic cnt_acc;
    logic place_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic last_i;
    logic last_j;
  } dp_stat_t;

endpackage

// ===== hw/rtl/rps_ctrl.sv =====
// Controller state machine for the rank placement sort unit.
// Depends on rps_pkg; drives the datapath through dp_cmd_t.
module rps_ctrl import rps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     start_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     strobe
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    strobe     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.i_zero = 1'b1;
        if (start) begin
          cmd.load = 1'b1;
          if (start_last) begin
            state_next = ST_LOAD_I;
          end
        end
      end
      ST_LOAD_I: begin
        state_next = ST_LATCH_I;
      end
      ST_LATCH_I: begin
        cmd.latch_cur = 1'b1;
        cmd.cnt_clr   = 1'b1;
        cmd.j_zero    = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.cnt_acc = 1'b1;
        cmd.j_step  = 1'b1;
        if (stat.last_j) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place_wr = 1'b1;
        if (stat.last_i) begin
          state_next = ST_EMIT_START;
        end else begin
          cmd.i_step = 1'b1;
          state_next = ST_LOAD_I;
        end
      end
      ST_EMIT_START: begin
        cmd.j_zero = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        strobe     = 1'b1;
        cmd.j_step = 1'b1;
        if (stat.last_j) begin
          cmd.fill_clr = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rps_datapath.sv =====
// Datapath for the rank placement sort unit: element store, rank counter,
// placement store and index counters. Depends on rps_pkg.
module rps_datapath import rps_pkg::*; #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  input  item_t    item,
  output dp_stat_t stat,
  output result_t  result
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ELEMENTS);

  logic signed [31:0] store  [MAX_ELEMENTS];
  logic signed [31:0] placed [MAX_ELEMENTS];

  logic [CNT_W-1:0]   fill;
  logic [IDX_W-1:0]   i;
  logic [IDX_W-1:0]   j;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] cur;
  logic signed [31:0] store_rd;
  logic signed [31:0] placed_rd;
  logic               full;
  logic               hit;

  assign full = (fill == FULL_CNT);

  always_comb begin
    if (cmd.j_zero) begin
      rd_addr = '0;
    end else if (cmd.j_step) begin
      rd_addr = j + IDX_W'(1);
    end else begin
      rd_addr = i;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      store[fill[IDX_W-1:0]] <= item.value;
    end
    store_rd <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.place_wr) begin
      placed[cnt] <= cur;
    end
    placed_rd <= placed[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.fill_clr) begin
      fill <= '0;
    end else if (cmd.load && !full) begin
      fill <= fill + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_zero) begin
      i <= '0;
    end else if (cmd.i_step) begin
      i <= i + IDX_W'(1);
    end
    if (cmd.j_zero || cmd.j_step) begin
      j <= rd_addr;
    end
    if (cmd.latch_cur) begin
      cur <= store_rd;
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_acc && hit) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // earlier equal elements push this one to a later slot
  assign hit = (store_rd < cur) || ((j < i) && (store_rd == cur));

  assign stat.last_i = ((CNT_W'(i) + CNT_W'(1)) == fill);
  assign stat.last_j = ((CNT_W'(j) + CNT_W'(1)) == fill);

  assign result.sorted_value = placed_rd;
  assign result.final_res    = stat.last_j;

endmodule

// ===== hw/rtl/rank_placement_sort_unit.sv =====
// Rank placement sort unit: collects signed 32-bit words, then emits them in
// ascending order, duplicates kept.
//
// Input: a word is taken at a rising edge with start high and busy low.
// Each taken word is stored (one cycle per word) unless MAX_ELEMENTS words
// are already held, in which case it is dropped. A word with last set closes
// the set (it is stored first if there is room) and busy goes high.
// Ranking: each element is read back and compared against all n stored
// elements, one compare per cycle; its rank (count of smaller elements plus
// earlier equal ones) is its slot in a second store. Each element passes
// through ST_LOAD_I, ST_LATCH_I, ST_SCAN and ST_PLACE in turn, as the store
// has a single read port. Output: the sorted set is then streamed, one word
// per cycle with strobe high; final_res flags the greatest element.
// The first strobe comes in ST_EMIT, entered through ST_EMIT_START after the
// last element's ST_PLACE; busy drops after the final result. The receiver
// cannot stall it. Reset clears the element count and returns the unit to
// idle; store contents are not cleared.
module rank_placement_sort_unit import rps_pkg::*; #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_last (item.last),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .strobe     (strobe)
  );

  rps_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .stat   (stat),
    .result (result)
  );

endmodule

// ===== verif/tb.sv =====
// Testbench for rank_placement_sort_unit: streams signed word sets, predicts
// the ascending output of each closed set and checks every result strobe.
// Depends on rps_pkg (item_t, result_t) and the unit RTL.
module tb;
  import rps_pkg::*;

  localparam int SET_CAP     = 32;
  localparam int ITEM_TARGET = 460;
  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_TAIL  = 64;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               typed;
    logic signed [31:0] want;
  } row_t;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  logic signed [31:0] open_set[$];
  result_t            sorted_due[$];
  int errors        = 0;
  int words_sent    = 0;
  int words_dropped = 0;
  int sets_closed   = 0;
  int words_checked = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;

  rank_placement_sort_unit #(.MAX_ELEMENTS(SET_CAP)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #2 clk = ~clk;

  // rank = smaller words plus earlier equal words; rank is the output slot
  function automatic void rank_and_queue();
    int n;
    int rank;
    logic signed [31:0] placed[SET_CAP];
    result_t r;
    n = open_set.size();
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++) begin
        if (open_set[j] < open_set[i] || (j < i && open_set[j] == open_set[i]))
          rank++;
      end
      placed[rank] = open_set[i];
    end
    for (int i = 0; i < n; i++) begin
      r.sorted_value = placed[i];
      r.final_res    = (i == n - 1);
      sorted_due.push_back(r);
    end
    open_set.delete();
    sets_closed++;
  endfunction

  function automatic logic signed [31:0] rand_word();
    logic signed [31:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w = $urandom;
      4, 5, 6: w = $signed($urandom_range(0, 15)) - 8;
      7: begin
        case ($urandom_range(0, 3))
          0: w = WORD_MIN;
          1: w = WORD_MAX;
          2: w = '0;
          default: w = -1;
        endcase
      end
      8: w = $urandom_range(0, 1) ? WORD_MIN + $urandom_range(0, 3)
                                  : WORD_MAX - $urandom_range(0, 3);
      default: w = 32'sd1 <<< $urandom_range(0, 31);
    endcase
    return w;
  endfunction

  task automatic send_word(input item_t w, input logic typed,
                           input logic signed [31:0] want);
    result_t r;
    item  <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
    if (open_set.size() < SET_CAP) open_set.push_back(w.value);
    else words_dropped++;
    if (typed) begin
      r.sorted_value = want;
      r.final_res    = 1'b1;
      sorted_due.push_back(r);
      open_set.delete();
      sets_closed++;
    end else if (w.last) begin
      rank_and_queue();
    end
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 10);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sorted_due.size() != 0 || busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected sorted word %0d final %0b", $time,
                 result.sorted_value, result.final_res);
        errors++;
      end else begin
        if (result.sorted_value !== sorted_due[0].sorted_value) begin
          $display("%0t: sorted_value expected %0d got %0d", $time,
                   sorted_due[0].sorted_value, result.sorted_value);
          errors++;
        end
        if (result.final_res !== sorted_due[0].final_res) begin
          $display("%0t: final_res expected %0b got %0b", $time,
                   sorted_due[0].final_res, result.final_res);
          errors++;
        end
        void'(sorted_due.pop_front());
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t  dir_rows[0:19];
    item_t w;
    int    set_len;
    int    set_idx;
    bit    paused_mid;

    dir_rows = '{
      '{WORD_MIN, 1'b1, 1'b1, WORD_MIN},
      '{WORD_MAX, 1'b1, 1'b1, WORD_MAX},
      '{32'sd0,   1'b1, 1'b1, 32'sd0},
      '{-32'sd1,  1'b1, 1'b1, -32'sd1},
      // duplicates mixed with both extremes
      '{32'sd5,   1'b0, 1'b0, 32'sd0},
      '{-32'sd3,  1'b0, 1'b0, 32'sd0},
      '{32'sd5,   1'b0, 1'b0, 32'sd0},
      '{WORD_MAX, 1'b0, 1'b0, 32'sd0},
      '{WORD_MIN, 1'b0, 1'b0, 32'sd0},
      '{-32'sd3,  1'b1, 1'b0, 32'sd0},
      // descending input
      '{32'sd3,   1'b0, 1'b0, 32'sd0},
      '{32'sd2,   1'b0, 1'b0, 32'sd0},
      '{32'sd1,   1'b0, 1'b0, 32'sd0},
      '{32'sd0,   1'b1, 1'b0, 32'sd0},
      // all equal, then a short mixed set
      '{32'sd7,   1'b0, 1'b0, 32'sd0},
      '{32'sd7,   1'b0, 1'b0, 32'sd0},
      '{32'sd7,   1'b1, 1'b0, 32'sd0},
      '{-32'sd2,  1'b0, 1'b0, 32'sd0},
      '{32'sd2,   1'b1, 1'b0, 32'sd0},
      '{32'sh5555_5555, 1'b1, 1'b1, 32'sh5555_5555}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      w.value = dir_rows[k].value;
      w.last  = dir_rows[k].last;
      send_word(w, dir_rows[k].typed, dir_rows[k].want);
      pace();
    end
    drain();

    set_idx    = 0;
    paused_mid = 1'b0;
    while (words_sent - words_dropped < ITEM_TARGET) begin
      // first sets hit the full store: last word dropped, last word exactly fills
      case (set_idx)
        0: set_len = 34;
        1: set_len = 33;
        2: set_len = 32;
        default: begin
          case ($urandom_range(0, 19))
            0: set_len = $urandom_range(9, 31);
            1: set_len = $urandom_range(32, 36);
            default: set_len = $urandom_range(1, 8);
          endcase
        end
      endcase
      for (int s = 0; s < set_len; s++) begin
        w.value = rand_word();
        w.last  = (s == set_len - 1);
        send_word(w, 1'b0, '0);
        pace();
      end
      set_idx++;
      if (!paused_mid && words_sent >= ITEM_TARGET / 2) begin
        drain();
        paused_mid = 1'b1;
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Sent %0d words in %0d sets, %0d dropped on a full store.",
             words_sent, sets_closed, words_dropped);
    $display("Checked %0d sorted words, %0d errors.", words_checked, errors);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rps_pkg.sv
hw/rtl/rps_ctrl.sv
hw/rtl/rps_datapath.sv
hw/rtl/rank_placement_sort_unit.sv
verif/tb.sv
